>>> src/spt_pkg.sv
`default_nettype none

package spt_pkg;

    // table size and coordinate width
    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 32;

    // derived widths
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = 2 * COORD_BITS;

    // fixed field widths on the ports
    localparam int FIELD_W = 32;
    localparam int POS_W   = 6;
    localparam int FILL_W  = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_FIND   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STS_INSERTED = 2'd0,
        STS_FULL     = 2'd1,
        STS_FOUND    = 2'd2,
        STS_MISSING  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } t_state;

    // one write port and one read port of the entry store
    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } t_mem_cmd;

    // shared compare unit outcome
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

    // finished result handed to the output register
    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] fill_count;
    } t_result;

endpackage

`default_nettype wire

>>> src/spt_ram.sv
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/spt_cmp.sv
`default_nettype none

module spt_cmp
    import spt_pkg::*;
(
    input  wire [ENTRY_W-1:0]    i_entry,
    input  wire [COORD_BITS-1:0] i_px,
    input  wire [COORD_BITS-1:0] i_py,
    output t_cmp                 o_cmp
);

    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;

    assign ex = i_entry[COORD_BITS-1:0];
    assign ey = i_entry[ENTRY_W-1:COORD_BITS];

    // y is the primary key, x breaks ties
    always_comb begin
        if (ey != $signed(i_py)) begin
            o_cmp.gt = ey > $signed(i_py);
        end else begin
            o_cmp.gt = ex > $signed(i_px);
        end
        o_cmp.eq = (ex == $signed(i_px)) && (ey == $signed(i_py));
    end

endmodule

`default_nettype wire

>>> src/spt_ctrl.sv
`default_nettype none

module spt_ctrl
    import spt_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  t_op                  i_op,
    input  wire [COORD_BITS-1:0] i_px,
    input  wire [COORD_BITS-1:0] i_py,
    output logic                 o_idle,
    output logic [COORD_BITS-1:0] o_px,
    output logic [COORD_BITS-1:0] o_py,
    input  t_cmp                 i_cmp,
    input  wire [ENTRY_W-1:0]    i_rdata,
    output t_mem_cmd             o_mem,
    output t_result              o_result,
    input  wire                  i_result_ready
);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    t_status             r_status, n_status;
    logic [COORD_BITS-1:0] r_px, n_px;
    logic [COORD_BITS-1:0] r_py, n_py;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    idx_dec;

    assign idx_dec = r_idx - CNT_W'(1);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // item payload and working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_px     <= n_px;
        r_py     <= n_py;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
    end

    // sequencer: scan, shift up, place, hand off
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_px     = r_px;
        n_py     = r_py;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_count  = r_count;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx[IDX_W-1:0];
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_idx[IDX_W-1:0];

        o_result.valid      = 1'b0;
        o_result.status     = r_status;
        o_result.position   = '0;
        o_result.fill_count = FILL_W'(r_count);
        if (r_status == STS_INSERTED || r_status == STS_FOUND) begin
            o_result.position = POS_W'(r_pos);
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_px  = i_px;
                    n_py  = i_py;
                    n_idx = '0;
                    n_pos = '0;
                    if (i_op == OP_INSERT && r_count == CNT_W'(CAPACITY)) begin
                        n_status = STS_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                // end of stored entries
                if (r_idx == r_count) begin
                    if (r_op == OP_INSERT) begin
                        n_pos   = r_idx[IDX_W-1:0];
                        n_state = S_PUT;
                    end else begin
                        n_status = STS_MISSING;
                        n_pos    = '0;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (r_op == OP_INSERT && i_cmp.gt) begin
                    n_pos   = r_idx[IDX_W-1:0];
                    n_idx   = r_count;
                    n_state = S_SHIFT_RD;
                end else if (r_op == OP_FIND && i_cmp.eq) begin
                    n_pos    = r_idx[IDX_W-1:0];
                    n_status = STS_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                o_mem.raddr = idx_dec[IDX_W-1:0];
                if (r_idx == CNT_W'(r_pos)) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                // move entry idx-1 up to idx
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[IDX_W-1:0];
                o_mem.wdata = i_rdata;
                n_idx       = idx_dec;
                n_state     = S_SHIFT_RD;
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos;
                o_mem.wdata = {r_py, r_px};
                n_count     = r_count + CNT_W'(1);
                n_status    = STS_INSERTED;
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_result.valid = 1'b1;
                if (i_result_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_px   = r_px;
    assign o_py   = r_py;

endmodule

`default_nettype wire

>>> src/sorted_point_table_top.sv
`default_nettype none

// channel   dir  tdata                               tuser
// s_axis    in   [31:0] point_x, [63:32] point_y     [0] opcode
// m_axis    out  [5:0] position, [12:6] fill_count   [1:0] status
//
// one item at a time over a one-write, one-read entry store and one shared compare unit
// find: entries are scanned from position 0 until an equal one or the end (a miss)
// insert: scan for the first greater entry, shift the tail up, then place; or append
// full-table insert: status full, no scan; synchronous active-low reset empties the table
// a result waits in the output register while the next item is taken; m_axis_tready
// low holds the sequencer only when a second result is ready behind the first

module sorted_point_table_top
    import spt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [63:0]  s_axis_tdata,   // point_x, point_y
    input  wire [0:0]   s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // position, fill_count, zero pad
    output logic [1:0]  m_axis_tuser    // status
);

    logic                  idle;
    logic                  start;
    logic                  out_free;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    t_cmp                  cmp;
    t_mem_cmd              mem;
    t_result               result;
    logic [ENTRY_W-1:0]    rdata;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [POS_W-1:0]      r_out_pos;
    logic [FILL_W-1:0]     r_out_fill;

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign out_free      = !r_out_valid || m_axis_tready;

    spt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (t_op'(s_axis_tuser[0])),
        .i_px           (s_axis_tdata[COORD_BITS-1:0]),
        .i_py           (s_axis_tdata[FIELD_W +: COORD_BITS]),
        .o_idle         (idle),
        .o_px           (px),
        .o_py           (py),
        .i_cmp          (cmp),
        .i_rdata        (rdata),
        .o_mem          (mem),
        .o_result       (result),
        .i_result_ready (out_free)
    );

    spt_cmp u_cmp (
        .i_entry (rdata),
        .i_px    (px),
        .i_py    (py),
        .o_cmp   (cmp)
    );

    spt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= result.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_free && result.valid) begin
            r_out_status <= result.status;
            r_out_pos    <= result.position;
            r_out_fill   <= result.fill_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {3'b000, r_out_fill, r_out_pos};

endmodule

`default_nettype wire

>>> dv/tb_sorted_point_table_top.sv
`timescale 1ns / 1ps

module tb_sorted_point_table_top;
    import spt_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 433;
    localparam int SETTLE_CYCLES = 150;

    // one result as the table should answer it
    typedef struct {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] fill_count;
    } table_answer_t;

    // mirror of the point table and the answers still owed by the block
    class sorted_table_tracker;
        logic signed [COORD_BITS-1:0] tab_x[CAPACITY];
        logic signed [COORD_BITS-1:0] tab_y[CAPACITY];
        int unsigned                  fill;
        table_answer_t                answers_due[$];
        int unsigned                  errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // apply one accepted beat to the mirror and queue its answer
        function void take_item(t_op op, logic [FIELD_W-1:0] px_raw,
                                logic [FIELD_W-1:0] py_raw);
            logic signed [COORD_BITS-1:0] px;
            logic signed [COORD_BITS-1:0] py;
            table_answer_t                ans;
            int unsigned                  slot;
            px             = px_raw[COORD_BITS-1:0];
            py             = py_raw[COORD_BITS-1:0];
            ans.position   = '0;
            slot           = 0;
            if (op == OP_INSERT) begin
                if (fill >= CAPACITY) begin
                    ans.status = STS_FULL;
                end else begin
                    // skip every entry not greater than the point, then open a gap
                    while (slot < fill && (tab_y[slot] < py ||
                           (tab_y[slot] == py && tab_x[slot] <= px)))
                        slot++;
                    for (int i = fill; i > slot; i--) begin
                        tab_x[i] = tab_x[i-1];
                        tab_y[i] = tab_y[i-1];
                    end
                    tab_x[slot]  = px;
                    tab_y[slot]  = py;
                    fill++;
                    ans.status   = STS_INSERTED;
                    ans.position = POS_W'(slot);
                end
            end else begin
                ans.status = STS_MISSING;
                for (int i = 0; i < fill; i++) begin
                    if (tab_x[i] == px && tab_y[i] == py) begin
                        ans.status   = STS_FOUND;
                        ans.position = POS_W'(i);
                        break;
                    end
                end
            end
            ans.fill_count = FILL_W'(fill);
            answers_due.push_back(ans);
        endfunction

        // compare one result beat with the oldest owed answer
        function void match_answer(t_status status, logic [POS_W-1:0] position,
                                   logic [FILL_W-1:0] fill_count);
            table_answer_t ans;
            if (answers_due.size() == 0) begin
                $display("%0t unexpected result: status %0d position %0d fill %0d",
                         $time, status, position, fill_count);
                errors++;
                return;
            end
            ans = answers_due.pop_front();
            if (status !== ans.status) begin
                $display("%0t status mismatch: expected %0d got %0d",
                         $time, ans.status, status);
                errors++;
            end
            if (position !== ans.position) begin
                $display("%0t position mismatch: expected %0d got %0d",
                         $time, ans.position, position);
                errors++;
            end
            if (fill_count !== ans.fill_count) begin
                $display("%0t fill_count mismatch: expected %0d got %0d",
                         $time, ans.fill_count, fill_count);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // point_x, point_y
    logic [0:0]  s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // position, fill_count, zero pad
    logic [1:0]  m_axis_tuser;   // status

    sorted_table_tracker tracker;
    int unsigned         tx_idle_pct;
    int unsigned         rx_stall_pct;
    int unsigned         quiet_cycles;

    sorted_point_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: check accepted beats, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_answer(t_status'(m_axis_tuser), m_axis_tdata[POS_W-1:0],
                                 m_axis_tdata[POS_W+FILL_W-1:POS_W]);
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t no beat for %0d cycles", $time, quiet_cycles);
            $display("** sorted_point_table_top: FAILED **");
            $finish;
        end
    end

    // present one point, returns at the edge that accepts it
    task automatic send_point(input t_op op, input logic [31:0] px, input logic [31:0] py);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_item(op, px, py);
    endtask

    // drop valid and hold off until every owed answer is back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.answers_due.size() != 0);
    endtask

    // coordinate biased to extremes and a small cluster so that keys collide
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return 32'($signed($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_op         op;
        logic [31:0] px;
        logic [31:0] py;
        int unsigned k;
        bit          calm;

        tracker       = new();
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        quiet_cycles  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty lookup, extremes, equal keys, signed ordering
        send_point(OP_FIND,   32'h0000_0000, 32'h0000_0000);
        send_point(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_point(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        send_point(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_point(OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_point(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_point(OP_INSERT, 32'hffff_ffff, 32'h0000_0000);
        send_point(OP_INSERT, 32'h0000_0001, 32'hffff_ffff);
        send_point(OP_INSERT, 32'hffff_ffff, 32'h0000_0001);
        send_point(OP_FIND,   32'h0000_0000, 32'h0000_0000);
        send_point(OP_FIND,   32'h7fff_ffff, 32'h7fff_ffff);
        send_point(OP_FIND,   32'h8000_0000, 32'h8000_0000);
        send_point(OP_FIND,   32'h0000_0000, 32'h0000_0001);
        send_point(OP_FIND,   32'h0000_0001, 32'h0000_0000);
        send_point(OP_INSERT, 32'haaaa_aaaa, 32'h5555_5555);
        send_point(OP_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
        send_point(OP_FIND,   32'haaaa_aaaa, 32'h5555_5555);
        send_point(OP_FIND,   32'h5555_5555, 32'h5555_5555);
        hold_until_drained();

        // random: mostly lookups with sparse inserts, more inserts once the table is full
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 48 == 0) begin
                    calm = (ph != 0) && ($urandom_range(3) == 0);
                    case (ph)
                        1:       begin tx_idle_pct = 71; rx_stall_pct = 0;  end
                        2:       begin tx_idle_pct = 0;  rx_stall_pct = 71; end
                        3:       begin tx_idle_pct = 27; rx_stall_pct = 27; end
                        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    endcase
                    if (calm) begin
                        tx_idle_pct  = 0;
                        rx_stall_pct = 0;
                    end
                end
                px = pick_coord();
                py = pick_coord();
                if (tracker.fill < CAPACITY)
                    op = ($urandom_range(19) == 0) ? OP_INSERT : OP_FIND;
                else
                    op = ($urandom_range(4) == 0) ? OP_INSERT : OP_FIND;
                if (tracker.fill > 0) begin
                    k = $urandom_range(tracker.fill - 1);
                    case ($urandom_range(19))
                        // exact copy of a stored point
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                            px = tracker.tab_x[k];
                            py = tracker.tab_y[k];
                        end
                        // same primary key, neighbor or random x
                        11, 12, 13: begin
                            py = tracker.tab_y[k];
                            px = $urandom_range(1) ? tracker.tab_x[k] + 32'd1 : px;
                        end
                        // same x, different y
                        14: begin
                            px = tracker.tab_x[k];
                            py = tracker.tab_y[k] ^ (32'd1 << $urandom_range(31));
                        end
                        default: ;
                    endcase
                end
                send_point(op, px, py);
            end
            hold_until_drained();
        end

        // wait out the tail, then report
        s_axis_tvalid <= 1'b0;
        while (tracker.answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.answers_due.size() != 0) begin
            $display("%0t %0d results never arrived", $time, tracker.answers_due.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("** sorted_point_table_top: PASSED **");
        end else begin
            $display("** sorted_point_table_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
src/spt_pkg.sv
src/spt_ram.sv
src/spt_cmp.sv
src/spt_ctrl.sv
src/sorted_point_table_top.sv
dv/tb_sorted_point_table_top.sv
